[sv/acs_pkg.sv]
// acs_pkg: constants shared by the adaptive channel smoother
// no dependencies
`default_nettype none

package acs_pkg;

    // number of channel stores, and the index width that addresses them
    localparam int unsigned CHANNELS = 16;
    localparam int unsigned CH_W     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    // field widths
    localparam int unsigned CHAN_W   = 4;
    localparam int unsigned VAL_W    = 24;
    localparam int unsigned WEIGHT_W = 7;

    // thresholds on the difference between sample and stored value
    localparam int unsigned JUMP_LIMIT  = 1000;
    localparam int unsigned ROUGH_LIMIT = 100;
    localparam int unsigned ROUGH_SHIFT = 4;

    // full weight, percent
    localparam logic [WEIGHT_W-1:0] WEIGHT_FULL = 7'd100;

    // reciprocal of 100 as 5243 / 2^19, exact for numerators below 10100
    localparam logic [12:0] RECIP_100 = 13'd5243;
    localparam int unsigned RECIP_SH  = 19;

    typedef logic [VAL_W-1:0] t_val;

endpackage

`default_nettype wire

[sv/adaptive_channel_smoother.sv]
// adaptive_channel_smoother: per-channel adaptive moving average, one sample a cycle unless stalled
// depends on acs_pkg
//
// usage
//   input channel : i_valid / o_ready, payload i_chan, i_sample, i_weight
//   output channel: o_valid / i_ready, payload o_filtered
//   each input beat yields exactly one output beat, in order
//   the beat is taken into an input register; the update of the channel
//   store and the result are formed from it and land in the result register
//   once that register is free or moves on, which raises o_valid
//   throughput is one beat per cycle while the receiver keeps up, also for
//   the same channel back to back: the store is written in the same cycle
//   it is read, so the next beat sees the new value; the limit is the
//   single read-modify-write of the channel store
//   a weight above 100 counts as 100; a channel beyond the store count
//   gives 0 and leaves every store unchanged
//   reset (i_rst_n low, synchronous) clears all channel stores to zero and
//   empties both registers
//   when the receiver stalls, the result register holds and the input
//   register still takes one more beat; o_ready then falls until the
//   result moves on
`default_nettype none

module adaptive_channel_smoother (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_valid,
    output logic                                o_ready,
    input  wire logic [acs_pkg::CHAN_W-1:0]     i_chan,
    input  wire logic [acs_pkg::VAL_W-1:0]      i_sample,
    input  wire logic [acs_pkg::WEIGHT_W-1:0]   i_weight,
    output logic                                o_valid,
    input  wire logic                           i_ready,
    output logic [acs_pkg::VAL_W-1:0]           o_filtered
);

    import acs_pkg::*;

    // input register
    logic                r_in_valid;
    logic [CHAN_W-1:0]   r_chan;
    t_val                r_sample;
    logic [WEIGHT_W-1:0] r_coef;

    // result register
    logic r_out_valid;
    t_val r_filtered;

    // channel stores
    t_val r_smoothed [CHANNELS];

    logic                w_advance;
    logic                w_take;
    logic [WEIGHT_W-1:0] w_wsat;
    logic [6:0]          w_chan_ext;
    logic [CH_W-1:0]     w_idx;
    logic                w_in_range;
    t_val                w_old;
    logic signed [25:0]  w_d;
    logic [25:0]         w_absd;
    logic                w_jump;
    logic                w_rough;
    logic signed [25:0]  w_rough_nv;
    logic signed [7:0]   w_d8;
    logic signed [15:0]  w_p;
    logic [13:0]         w_pabs;
    logic [13:0]         w_padj;
    logic [26:0]         w_qprod;
    logic [6:0]          w_q;
    t_val                w_fine_nv;
    t_val                w_nv;
    t_val                n_filtered;

    // handshake
    assign w_advance = r_in_valid && (!r_out_valid || i_ready);
    assign o_ready   = !r_in_valid || w_advance;
    assign w_take    = i_valid && o_ready;
    assign o_valid   = r_out_valid;
    assign o_filtered = r_filtered;

    // weight saturation; 100 minus the weight is kept as the sample's share
    assign w_wsat = (i_weight > WEIGHT_FULL) ? WEIGHT_FULL : i_weight;

    // channel lookup
    assign w_chan_ext = {{(7 - CHAN_W){1'b0}}, r_chan};
    assign w_idx      = w_chan_ext[CH_W-1:0];
    assign w_in_range = (w_chan_ext < 7'(CHANNELS));
    assign w_old      = r_smoothed[w_idx];

    // difference and mode selection
    assign w_d     = $signed({2'b00, r_sample}) - $signed({2'b00, w_old});
    assign w_absd  = w_d[25] ? 26'(-w_d) : 26'(w_d);
    assign w_jump  = (w_absd >= 26'(JUMP_LIMIT));
    assign w_rough = (w_absd >= 26'(ROUGH_LIMIT));

    // rough step: move by the difference shifted right arithmetically
    assign w_rough_nv = $signed({2'b00, w_old}) + (w_d >>> ROUGH_SHIFT);

    // fine step: old + floor(coef * d / 100), |d| below 100 here
    assign w_d8    = w_d[7:0];
    assign w_p     = $signed({1'b0, r_coef}) * w_d8;
    assign w_pabs  = w_p[15] ? 14'(-w_p) : 14'(w_p);
    assign w_padj  = w_p[15] ? (w_pabs + 14'd99) : w_pabs;
    assign w_qprod = 27'(w_padj) * 27'(RECIP_100);
    assign w_q     = w_qprod[RECIP_SH +: 7];
    assign w_fine_nv = w_p[15] ? (w_old - t_val'(w_q)) : (w_old + t_val'(w_q));

    // new value
    always_comb begin
        priority if (w_jump) begin
            w_nv = r_sample;
        end else if (w_rough) begin
            w_nv = w_rough_nv[VAL_W-1:0];
        end else begin
            w_nv = w_fine_nv;
        end
        n_filtered = w_in_range ? w_nv : '0;
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
        if (w_take) begin
            r_chan   <= i_chan;
            r_sample <= i_sample;
            r_coef   <= WEIGHT_FULL - w_wsat;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
        if (w_advance) begin
            r_filtered <= n_filtered;
        end
    end

    // channel stores
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < CHANNELS; i++) begin
                r_smoothed[i] <= '0;
            end
        end else if (w_advance && w_in_range) begin
            r_smoothed[w_idx] <= w_nv;
        end
    end

    // checks
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    a_advance_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_advance |=> o_valid)
        else $error("finished beat did not reach the result register");

    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> (r_in_valid && r_out_valid && !i_ready))
        else $error("input refused while a register was free");

    a_jump_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_advance && w_in_range && w_jump) |=> (o_filtered == $past(r_sample)))
        else $error("large step did not take the sample");

endmodule

`default_nettype wire
